// File: sv/small_isa_execute_writeback_unit_assert.svh
// ----------------------------------------------------------------------------
// small_isa_execute_writeback_unit_assert.svh
// Assertion macros for the execute/writeback unit.
// ----------------------------------------------------------------------------
`ifndef SMALL_ISA_EXECUTE_WRITEBACK_UNIT_ASSERT_SVH
`define SMALL_ISA_EXECUTE_WRITEBACK_UNIT_ASSERT_SVH

// same-cycle implication
`define SIEWB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SIEWB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/siewb_pkg.sv
// ----------------------------------------------------------------------------
// siewb_pkg
// Sizes, opcodes, fault codes and Q16.16 helpers of the execute unit.
// ----------------------------------------------------------------------------
package siewb_pkg;

   localparam int REG_COUNT     = 32;
   localparam int MEM_WORDS     = 512;
   localparam int PROGRAM_WORDS = 64;

   localparam int RfAw     = $clog2(REG_COUNT);
   localparam int MemAw    = $clog2(MEM_WORDS);
   localparam int DivSteps = 48;
   localparam int DivCntW  = $clog2(DivSteps);

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,  OP_ADDI = 5'd1,  OP_SUB  = 5'd2,  OP_SUBI = 5'd3,
      OP_MUL  = 5'd4,  OP_DIV  = 5'd5,  OP_MOD  = 5'd6,  OP_LD   = 5'd7,
      OP_LDI  = 5'd8,  OP_MV   = 5'd9,  OP_STR  = 5'd10, OP_BRNE = 5'd11,
      OP_BRE  = 5'd12, OP_BRLT = 5'd13, OP_BR   = 5'd14, OP_CMP  = 5'd15,
      OP_HALT = 5'd16
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_DIV0 = 2'd1,
      FAULT_ADDR = 2'd2
   } fault_type;

   // integer part, truncated toward zero
   function automatic logic signed [16:0] int_part(input logic signed [31:0] v);
      logic signed [16:0] hi;
      hi = 17'(v >>> 16);
      return hi + 17'(v[31] && (v[15:0] != 16'd0));
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

// File: sv/small_isa_execute_writeback_unit.sv
// ----------------------------------------------------------------------------
// small_isa_execute_writeback_unit
// Executes one decoded instruction per item against a Q16.16 register file
// and data memory, writes back, and reports one result item.
// ----------------------------------------------------------------------------
//  channel  | dir | ports                        | payload
//  request  | in  | req_tvalid/tready/tdata[47:0] | one decoded instruction
//  response | out | rsp_tvalid/tready/tdata[71:0] | value, dest, branch, status
//
//  Sequence: one item at a time; most ops take three register-file reads,
//  execute and writeback; mul and ld add a product or memory-read state, div
//  and mod add 48 steps of the shared restoring divider plus fix-up.
//  Reset: a pass zeroes every data memory word, no item accepted meanwhile;
//  register file entries read as zero through per-entry valid bits.
//  Stalls: a held result blocks writeback of the next item, then its input.
// ----------------------------------------------------------------------------
`include "small_isa_execute_writeback_unit_assert.svh"

module small_isa_execute_writeback_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] mode, [9:5] reg_first, [14:10] reg_second, [19:15] reg_third,
   // [35:20] immediate, [41:36] branch_target, [47:42] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] result_value, [40:32] dest_index, [41] to_memory,
   // [42] branch_taken, [48:43] next_target, [49] halted, [51:50] fault,
   // [67:52] executed_total, [71:68] zero
   output logic [71:0] rsp_tdata
);

   localparam int RfAw  = siewb_pkg::RfAw;
   localparam int MemAw = siewb_pkg::MemAw;
   localparam int CntW  = siewb_pkg::DivCntW;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b00_0000_0001,
      ST_IDLE  = 10'b00_0000_0010,
      ST_RDA   = 10'b00_0000_0100,
      ST_RDB   = 10'b00_0000_1000,
      ST_RDC   = 10'b00_0001_0000,
      ST_EXEC  = 10'b00_0010_0000,
      ST_MULT  = 10'b00_0100_0000,
      ST_DIV   = 10'b00_1000_0000,
      ST_DFIN  = 10'b01_0000_0000,
      ST_MEM   = 10'b10_0000_0000
   } state_type;
   // writeback gate of the staged result
   typedef enum logic {WB_NO = 1'b0, WB_GO = 1'b1} wb_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;

   // latched instruction and operands
   logic [4:0]          mode_ff, mode_in;
   logic [4:0]          r1_ff, r1_in, r3_ff, r3_in;
   logic signed [15:0]  imm_ff, imm_in;
   logic [5:0]          tgt_ff, tgt_in;
   logic signed [31:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [63:0]  prod_ff, prod_in;

   // shared divider
   logic [47:0]         dd_ff, dd_in;
   logic [31:0]         rem_ff, rem_in, den_ff, den_in;
   logic [CntW-1:0]     dcnt_ff, dcnt_in;
   logic                neg_ff, neg_in, is_mod_ff, is_mod_in;

   // staged result
   logic signed [31:0]  res_value_ff, res_value_in;
   logic [8:0]          res_dest_ff, res_dest_in;
   logic                res_tomem_ff, res_tomem_in, res_taken_ff, res_taken_in;
   logic                res_halt_ff, res_halt_in;
   siewb_pkg::fault_type res_fault_ff, res_fault_in;
   logic                rf_wp_ff, rf_wp_in, mem_wp_ff, mem_wp_in;
   logic [MemAw-1:0]    maddr_ff, maddr_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  out_value_ff, out_value_in;
   logic [8:0]          out_dest_ff, out_dest_in;
   logic                out_tomem_ff, out_tomem_in, out_taken_ff, out_taken_in;
   logic [5:0]          out_tgt_ff, out_tgt_in;
   logic                out_halt_ff, out_halt_in;
   siewb_pkg::fault_type out_fault_ff, out_fault_in;
   logic [15:0]         count_ff, count_in;

   logic [MemAw-1:0]    clr_ff, clr_in;
   logic [siewb_pkg::REG_COUNT-1:0] rf_valid_ff;
   logic                rf_vld_rd_ff, rf_inr_rd_ff;

   // memory ports
   logic [4:0]          rf_rd_idx;
   logic [31:0]         rf_rd_data, dm_rd_data, dm_wd;
   logic                rf_we, dm_we;
   logic [MemAw-1:0]    dm_wa, dm_ra;
   logic signed [31:0]  rf_q;
   wb_type              wb;

   // execute helpers
   siewb_pkg::op_type   op;
   logic signed [16:0]  ia, ib;
   logic signed [17:0]  addr;
   logic                addr_ok;
   logic signed [31:0]  imm_q, wval;
   logic                wreg;
   logic [31:0]         a_mag, b_mag;
   logic [16:0]         ia_mag, ib_mag;
   logic signed [63:0]  p_sh;
   logic signed [47:0]  p_adj;
   logic [32:0]         d_sh;
   logic                d_ge;
   logic signed [15:0]  m_val;

   siewb_ram #(.WIDTH(32), .DEPTH(siewb_pkg::REG_COUNT)) u_rf (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (r1_ff[RfAw-1:0]),
      .wr_data (res_value_ff),
      .rd_addr (rf_rd_idx[RfAw-1:0]),
      .rd_data (rf_rd_data)
   );

   siewb_ram #(.WIDTH(32), .DEPTH(siewb_pkg::MEM_WORDS)) u_dm (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_wa),
      .wr_data (dm_wd),
      .rd_addr (dm_ra),
      .rd_data (dm_rd_data)
   );

   // never-written registers read as zero
   assign rf_q = (rf_vld_rd_ff && rf_inr_rd_ff) ? rf_rd_data : 32'sd0;

   assign op     = siewb_pkg::op_type'(mode_ff);
   assign ia     = siewb_pkg::int_part(a_ff);
   assign ib     = siewb_pkg::int_part(b_ff);
   assign addr   = 18'(ia) + 18'(ib);
   assign addr_ok = !addr[17] && (addr < 18'(siewb_pkg::MEM_WORDS));
   assign imm_q  = {imm_ff, 16'd0};
   assign a_mag  = a_ff[31] ? 32'(-a_ff) : a_ff;
   assign b_mag  = b_ff[31] ? 32'(-b_ff) : b_ff;
   assign ia_mag = ia[16] ? 17'(-ia) : ia;
   assign ib_mag = ib[16] ? 17'(-ib) : ib;
   assign p_sh   = prod_ff >>> 16;
   assign p_adj  = p_sh[47:0] + 48'(prod_ff[63] && (prod_ff[15:0] != 16'd0));
   assign d_sh   = {rem_ff, dd_ff[47]};
   assign d_ge   = d_sh >= {1'b0, den_ff};
   assign m_val  = neg_ff ? 16'(-rem_ff[15:0]) : rem_ff[15:0];

   // done slot: writeback only when the output register can take the item
   assign wb = (done_ff && (!rsp_valid_ff || rsp_tready)) ? WB_GO : WB_NO;

   assign rf_we = (wb == WB_GO) && rf_wp_ff &&
                  ({1'b0, r1_ff} < 6'(siewb_pkg::REG_COUNT));
   assign dm_we = (state_ff == ST_CLEAR) || ((wb == WB_GO) && mem_wp_ff);
   assign dm_wa = (state_ff == ST_CLEAR) ? clr_ff : maddr_ff;
   assign dm_wd = (state_ff == ST_CLEAR) ? 32'd0 : res_value_ff;
   assign dm_ra = addr[MemAw-1:0];

   assign req_tready = (state_ff == ST_IDLE) && !done_ff;

   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      mode_in      = mode_ff;
      r1_in        = r1_ff;
      r3_in        = r3_ff;
      imm_in       = imm_ff;
      tgt_in       = tgt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      prod_in      = prod_ff;
      dd_in        = dd_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      is_mod_in    = is_mod_ff;
      res_value_in = res_value_ff;
      res_dest_in  = res_dest_ff;
      res_tomem_in = res_tomem_ff;
      res_taken_in = res_taken_ff;
      res_halt_in  = res_halt_ff;
      res_fault_in = res_fault_ff;
      rf_wp_in     = rf_wp_ff;
      mem_wp_in    = mem_wp_ff;
      maddr_in     = maddr_ff;
      clr_in       = clr_ff;
      rf_rd_idx    = r1_ff;
      wval         = 32'sd0;
      wreg         = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_dest_in  = out_dest_ff;
      out_tomem_in = out_tomem_ff;
      out_taken_in = out_taken_ff;
      out_tgt_in   = out_tgt_ff;
      out_halt_in  = out_halt_ff;
      out_fault_in = out_fault_ff;
      count_in     = count_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MemAw'(siewb_pkg::MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rf_rd_idx = req_tdata[14:10];
            if (req_tvalid && req_tready) begin
               mode_in  = req_tdata[4:0];
               r1_in    = req_tdata[9:5];
               r3_in    = req_tdata[19:15];
               imm_in   = req_tdata[35:20];
               tgt_in   = req_tdata[41:36];
               state_in = ST_RDA;
            end
         end
         ST_RDA: begin
            a_in      = rf_q;
            rf_rd_idx = r3_ff;
            state_in  = ST_RDB;
         end
         ST_RDB: begin
            b_in      = rf_q;
            rf_rd_idx = r1_ff;
            state_in  = ST_RDC;
         end
         ST_RDC: begin
            c_in     = rf_q;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_value_in = 32'sd0;
            res_dest_in  = 9'd0;
            res_tomem_in = 1'b0;
            res_taken_in = 1'b0;
            res_halt_in  = 1'b0;
            res_fault_in = siewb_pkg::FAULT_NONE;
            rf_wp_in     = 1'b0;
            mem_wp_in    = 1'b0;
            state_in     = ST_IDLE;
            done_in      = 1'b1;
            unique case (op)
               siewb_pkg::OP_ADD: begin
                  wval = siewb_pkg::sat32(48'(a_ff) + 48'(b_ff));
                  wreg = 1'b1;
               end
               siewb_pkg::OP_ADDI: begin
                  wval = siewb_pkg::sat32(48'(a_ff) + 48'(imm_q));
                  wreg = 1'b1;
               end
               siewb_pkg::OP_SUB: begin
                  wval = siewb_pkg::sat32(48'(a_ff) - 48'(b_ff));
                  wreg = 1'b1;
               end
               siewb_pkg::OP_SUBI: begin
                  wval = siewb_pkg::sat32(48'(a_ff) - 48'(imm_q));
                  wreg = 1'b1;
               end
               siewb_pkg::OP_MUL: begin
                  prod_in  = a_ff * b_ff;
                  state_in = ST_MULT;
                  done_in  = 1'b0;
               end
               siewb_pkg::OP_DIV: begin
                  if (b_ff == 32'sd0) begin
                     res_fault_in = siewb_pkg::FAULT_DIV0;
                  end else begin
                     dd_in     = {a_mag, 16'd0};
                     rem_in    = 32'd0;
                     den_in    = b_mag;
                     dcnt_in   = '0;
                     neg_in    = a_ff[31] ^ b_ff[31];
                     is_mod_in = 1'b0;
                     state_in  = ST_DIV;
                     done_in   = 1'b0;
                  end
               end
               siewb_pkg::OP_MOD: begin
                  if (ib == 17'sd0) begin
                     res_fault_in = siewb_pkg::FAULT_DIV0;
                  end else begin
                     dd_in     = 48'(ia_mag);
                     rem_in    = 32'd0;
                     den_in    = 32'(ib_mag);
                     dcnt_in   = '0;
                     neg_in    = ia[16];
                     is_mod_in = 1'b1;
                     state_in  = ST_DIV;
                     done_in   = 1'b0;
                  end
               end
               siewb_pkg::OP_LD: begin
                  if (!addr_ok) begin
                     res_fault_in = siewb_pkg::FAULT_ADDR;
                  end else begin
                     state_in = ST_MEM;
                     done_in  = 1'b0;
                  end
               end
               siewb_pkg::OP_LDI: begin
                  wval = imm_q;
                  wreg = 1'b1;
               end
               siewb_pkg::OP_MV: begin
                  wval = a_ff;
                  wreg = 1'b1;
               end
               siewb_pkg::OP_STR: begin
                  if (!addr_ok) begin
                     res_fault_in = siewb_pkg::FAULT_ADDR;
                  end else begin
                     res_value_in = c_ff;
                     res_dest_in  = addr[8:0];
                     res_tomem_in = 1'b1;
                     mem_wp_in    = 1'b1;
                     maddr_in     = addr[MemAw-1:0];
                  end
               end
               siewb_pkg::OP_BRNE: res_taken_in = (c_ff != a_ff);
               siewb_pkg::OP_BRE:  res_taken_in = (c_ff == a_ff);
               // taken when NOT less
               siewb_pkg::OP_BRLT: res_taken_in = !(c_ff < a_ff);
               siewb_pkg::OP_BR:   res_taken_in = 1'b1;
               siewb_pkg::OP_CMP: begin
                  wval = (a_ff < b_ff) ? -32'sh0001_0000 :
                         ((a_ff == b_ff) ? 32'sd0 : 32'sh0001_0000);
                  wreg = 1'b1;
               end
               siewb_pkg::OP_HALT: res_halt_in = 1'b1;
               default: ;
            endcase
         end
         ST_MULT: begin
            wval     = siewb_pkg::sat32(p_adj);
            wreg     = 1'b1;
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         ST_DIV: begin
            rem_in  = d_ge ? 32'(d_sh - {1'b0, den_ff}) : d_sh[31:0];
            dd_in   = {dd_ff[46:0], d_ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == CntW'(siewb_pkg::DivSteps - 1)) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            if (is_mod_ff) begin
               wval = {m_val, 16'd0};
            end else if (!neg_ff) begin
               wval = (dd_ff > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : dd_ff[31:0];
            end else begin
               wval = (dd_ff > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                   : 32'(-dd_ff[31:0]);
            end
            wreg     = 1'b1;
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         ST_MEM: begin
            wval     = dm_rd_data;
            wreg     = 1'b1;
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase

      if (wreg) begin
         res_value_in = wval;
         res_dest_in  = {4'd0, r1_ff};
         rf_wp_in     = 1'b1;
      end

      // writeback slot: move the staged result to the output register
      if (wb == WB_GO) begin
         done_in      = 1'b0;
         rsp_valid_in = 1'b1;
         out_value_in = res_value_ff;
         out_dest_in  = res_dest_ff;
         out_tomem_in = res_tomem_ff;
         out_taken_in = res_taken_ff;
         out_tgt_in   = res_taken_ff ? 6'(tgt_ff % siewb_pkg::PROGRAM_WORDS) : 6'd0;
         out_halt_in  = res_halt_ff;
         out_fault_in = res_fault_ff;
         if (count_ff != 16'hFFFF) begin
            count_in = count_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         done_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 16'd0;
         rf_valid_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (rf_we) begin
            rf_valid_ff[r1_ff[RfAw-1:0]] <= 1'b1;
         end
      end
      rf_vld_rd_ff <= rf_valid_ff[rf_rd_idx[RfAw-1:0]];
      rf_inr_rd_ff <= ({1'b0, rf_rd_idx} < 6'(siewb_pkg::REG_COUNT));
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      r1_ff        <= r1_in;
      r3_ff        <= r3_in;
      imm_ff       <= imm_in;
      tgt_ff       <= tgt_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      prod_ff      <= prod_in;
      dd_ff        <= dd_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      dcnt_ff      <= dcnt_in;
      neg_ff       <= neg_in;
      is_mod_ff    <= is_mod_in;
      res_value_ff <= res_value_in;
      res_dest_ff  <= res_dest_in;
      res_tomem_ff <= res_tomem_in;
      res_taken_ff <= res_taken_in;
      res_halt_ff  <= res_halt_in;
      res_fault_ff <= res_fault_in;
      rf_wp_ff     <= rf_wp_in;
      mem_wp_ff    <= mem_wp_in;
      maddr_ff     <= maddr_in;
      out_value_ff <= out_value_in;
      out_dest_ff  <= out_dest_in;
      out_tomem_ff <= out_tomem_in;
      out_taken_ff <= out_taken_in;
      out_tgt_ff   <= out_tgt_in;
      out_halt_ff  <= out_halt_in;
      out_fault_ff <= out_fault_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, count_ff, out_fault_ff, out_halt_ff, out_tgt_ff,
                        out_taken_ff, out_tomem_ff, out_dest_ff, out_value_ff};

   `SIEWB_ASSERT_NXT(a_busy_after_accept, clock, reset,
      req_tvalid && req_tready, !req_tready, "ready right after accept")
   `SIEWB_ASSERT_IMP(a_fault_no_write, clock, reset,
      rsp_valid_ff && (out_fault_ff != siewb_pkg::FAULT_NONE),
      (out_value_ff == 32'sd0) && !out_tomem_ff && (out_dest_ff == 9'd0),
      "faulted item carries a write")
   `SIEWB_ASSERT_IMP(a_one_write, clock, reset,
      rf_we, !dm_we, "register and memory written together")

endmodule

// File: sv/siewb_ram.sv
// ----------------------------------------------------------------------------
// siewb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module siewb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
